// ===== sv/cctalk_reply_frame_checker_core_assert.svh =====
`ifndef CCTALK_REPLY_FRAME_CHECKER_CORE_ASSERT_SVH
`define CCTALK_REPLY_FRAME_CHECKER_CORE_ASSERT_SVH

// Both macros expect clk and rst_n in scope.
`define CCRFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define CCRFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ccrfc_pkg.sv =====
package ccrfc_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned POS_W      = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HOST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEVICE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLY   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NAK    = 3'd4;

    localparam logic        MODE_RESET   = 1'b0;
    localparam logic [7:0]  HOST_RESET   = 8'd1;
    localparam logic [7:0]  DEVICE_RESET = 8'd2;
    localparam logic [15:0] POLY_RESET   = 16'h1021;
    localparam logic [7:0]  NAK_RESET    = 8'd5;

    localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] POS_LENGTH = 9'd1;
    localparam logic [POS_W-1:0] POS_SOURCE = 9'd2;
    localparam logic [POS_W-1:0] POS_HEADER = 9'd3;
    localparam logic [POS_W-1:0] POS_MIN_LAST = 9'd4;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_DEST     = 3'd2,
        ST_LENGTH   = 3'd3,
        ST_SOURCE   = 3'd4,
        ST_HEADER   = 3'd5,
        ST_CHECKSUM = 3'd6
    } status_t;

    typedef struct packed {
        logic        protocol_mode;
        logic [7:0]  host_address;
        logic [7:0]  device_address;
        logic [15:0] crc_polynomial;
        logic [7:0]  nak_header;
    } cfg_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        status_t    status;
        logic       reply_nak;
    } res_item_t;

    // One byte folded into the CRC, MSB first.
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15])
            begin
                crc = {crc[14:0], 1'b0} ^ poly;
            end
            else
            begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ===== sv/ccrfc_ifs.sv =====
interface ccrfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface ccrfc_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic [2:0] status;
    logic       reply_nak;

    modport source (output valid, output out_byte, output is_status, output status,
                    output reply_nak, input ready);
    modport sink   (input valid, input out_byte, input is_status, input status,
                    input reply_nak, output ready);
endinterface

// ===== sv/ccrfc_cfg_regs.sv =====
module ccrfc_cfg_regs
    import ccrfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_MODE:   cfg_next.protocol_mode  = cfg_data[0];
                CFG_IDX_HOST:   cfg_next.host_address   = cfg_data[7:0];
                CFG_IDX_DEVICE: cfg_next.device_address = cfg_data[7:0];
                CFG_IDX_POLY:   cfg_next.crc_polynomial = cfg_data[15:0];
                CFG_IDX_NAK:    cfg_next.nak_header     = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.protocol_mode  <= MODE_RESET;
            cfg_reg.host_address   <= HOST_RESET;
            cfg_reg.device_address <= DEVICE_RESET;
            cfg_reg.crc_polynomial <= POLY_RESET;
            cfg_reg.nak_header     <= NAK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/ccrfc_in_stage.sv =====
module ccrfc_in_stage
    import ccrfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    ccrfc_rx_if.sink rx,
    input  logic     advance,
    output logic     item_valid,
    output rx_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    rx_item_t item_reg;
    logic     take;

    assign rx.ready = !valid_reg || advance;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.rx_byte   <= rx.rx_byte;
            item_reg.frame_end <= rx.frame_end;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/ccrfc_frame_engine.sv =====
module ccrfc_frame_engine
    import ccrfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      advance,
    input  rx_item_t  item,
    output logic      res_valid,
    output res_item_t res
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       len_reg;
    logic [7:0]       len_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [7:0]       crc_low_reg;
    logic [7:0]       crc_low_next;
    logic [7:0]       held_reg;
    logic [7:0]       hdr_reg;
    logic [7:0]       hdr_next;
    status_t          ferr_reg;
    status_t          ferr_next;
    status_t          st;
    logic [7:0]       b;
    logic             no_err;

    assign b      = item.rx_byte;
    assign no_err = (ferr_reg == ST_OK);

    always_comb
    begin
        crc_next = crc_reg;
        if (pos_reg != '0 && pos_reg != POS_HEADER)
        begin
            crc_next = crc_fold(crc_reg, held_reg, cfg.crc_polynomial);
        end
        sum_next     = sum_reg + b;
        len_next     = len_reg;
        crc_low_next = crc_low_reg;
        hdr_next     = hdr_reg;
        ferr_next    = ferr_reg;
        case (pos_reg)
            '0:
            begin
                if (b != cfg.host_address && no_err)
                begin
                    ferr_next = ST_DEST;
                end
            end
            POS_LENGTH:
            begin
                len_next = b;
            end
            POS_SOURCE:
            begin
                crc_low_next = b;
                if (!cfg.protocol_mode && b != cfg.device_address && no_err)
                begin
                    ferr_next = ST_SOURCE;
                end
            end
            POS_HEADER:
            begin
                hdr_next = b;
                if (b != 8'd0 && b != cfg.nak_header && no_err)
                begin
                    ferr_next = ST_HEADER;
                end
            end
            default:
            begin
                ferr_next = ferr_reg;
            end
        endcase
        pos_next = (pos_reg != POS_MAX) ? pos_reg + 1'b1 : pos_reg;
    end

    // Frame-end status, first failing check wins.
    always_comb
    begin
        if (pos_reg < POS_MIN_LAST)
        begin
            st = ST_SHORT;
        end
        else if (ferr_reg == ST_DEST)
        begin
            st = ST_DEST;
        end
        else if ((pos_reg - POS_MIN_LAST) != {1'b0, len_reg})
        begin
            st = ST_LENGTH;
        end
        else if (!no_err)
        begin
            st = ferr_reg;
        end
        else if (!cfg.protocol_mode)
        begin
            st = (sum_next == 8'd0) ? ST_OK : ST_CHECKSUM;
        end
        else
        begin
            st = (crc_next == {b, crc_low_reg}) ? ST_OK : ST_CHECKSUM;
        end
    end

    always_comb
    begin
        res = '{out_byte: 8'd0, is_status: 1'b0, status: ST_OK, reply_nak: 1'b0};
        res_valid = 1'b0;
        if (item.frame_end)
        begin
            res_valid     = 1'b1;
            res.is_status = 1'b1;
            res.status    = st;
            res.reply_nak = (st == ST_OK) && (len_reg == 8'd0) && (hdr_reg == cfg.nak_header);
        end
        else if (pos_reg >= POS_HEADER)
        begin
            res_valid    = 1'b1;
            res.out_byte = b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            len_reg     <= '0;
            sum_reg     <= '0;
            crc_reg     <= '0;
            crc_low_reg <= '0;
            held_reg    <= '0;
            hdr_reg     <= '0;
            ferr_reg    <= ST_OK;
        end
        else if (advance)
        begin
            if (item.frame_end)
            begin
                pos_reg     <= '0;
                len_reg     <= '0;
                sum_reg     <= '0;
                crc_reg     <= '0;
                crc_low_reg <= '0;
                held_reg    <= '0;
                hdr_reg     <= '0;
                ferr_reg    <= ST_OK;
            end
            else
            begin
                pos_reg     <= pos_next;
                len_reg     <= len_next;
                sum_reg     <= sum_next;
                crc_reg     <= crc_next;
                crc_low_reg <= crc_low_next;
                held_reg    <= b;
                hdr_reg     <= hdr_next;
                ferr_reg    <= ferr_next;
            end
        end
    end

endmodule

// ===== sv/ccrfc_out_stage.sv =====
module ccrfc_out_stage
    import ccrfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  logic         res_valid,
    input  res_item_t    res_in,
    output logic         out_free,
    ccrfc_res_if.source  res
);

    logic      valid_reg;
    logic      valid_next;
    res_item_t res_reg;

    assign out_free = !valid_reg || res.ready;

    always_comb
    begin
        valid_next = valid_reg && !res.ready;
        if (advance)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res_in;
        end
    end

    assign res.valid     = valid_reg;
    assign res.out_byte  = res_reg.out_byte;
    assign res.is_status = res_reg.is_status;
    assign res.status    = res_reg.status;
    assign res.reply_nak = res_reg.reply_nak;

endmodule

// ===== sv/cctalk_reply_frame_checker_core.sv =====
// Checks received ccTalk reply frames fed one byte per item, the last byte
// marked by frame_end. Header and data bytes come out as payload items, and
// each frame ends in one status item that gives the first failing check, in
// a fixed order, and a NAK-reply flag. The block takes one byte every clock
// cycle unless res.ready holds back the result register; a byte passes an
// input register and then a result register, and the per-byte CRC step is a
// single unrolled pass of eight shifts. Configuration writes take effect at
// once and are meant for moments when no frame is in progress.
`include "cctalk_reply_frame_checker_core_assert.svh"

module cctalk_reply_frame_checker_core
    import ccrfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ccrfc_rx_if.sink              rx,
    ccrfc_res_if.source           res
);

    cfg_t      cfg;
    logic      item_valid;
    rx_item_t  item;
    logic      out_free;
    logic      advance;
    logic      eng_valid;
    res_item_t eng_res;

    assign advance = item_valid && out_free;

    ccrfc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ccrfc_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ccrfc_frame_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .advance   (advance),
        .item      (item),
        .res_valid (eng_valid),
        .res       (eng_res)
    );

    ccrfc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .res_valid (eng_valid),
        .res_in    (eng_res),
        .out_free  (out_free),
        .res       (res)
    );

    `CCRFC_ASSERT_NEXT(a_frame_end_gives_status, advance && item.frame_end, res.valid && res.is_status, "frame end did not produce a status item")
    `CCRFC_ASSERT_NEXT(a_result_follows_engine, advance, res.valid == $past(eng_valid), "result register does not follow the engine")
    `CCRFC_ASSERT_SAME(a_nak_only_on_ok, res.valid && res.reply_nak, res.is_status && res.status == ST_OK, "NAK flag outside a good status item")

endmodule
